[design/brng_pkg.sv]
// Shared types, codes and sizes for the boot range allocator.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package brng_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int PAGE_BITS   = 12;
    localparam int ADDR_W      = 48;
    localparam int PAGES_W     = 36;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam addr_t PAGE_MASK = addr_t'((64'd1 << PAGE_BITS) - 64'd1);

    typedef struct packed {
        addr_t start;
        addr_t len;
    } entry_t;

    // commands
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_RSV   = 2'd1;
    localparam logic [1:0] CMD_ALLOC = 2'd2;

    // result status
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FREE_FULL  = 2'd1;
    localparam logic [1:0] ST_RESV_FULL  = 2'd2;
    localparam logic [1:0] ST_ALLOC_FAIL = 2'd3;

    // chain operations
    typedef logic [2:0] op_t;
    localparam op_t OP_HOLD = 3'd0;  // nothing moves
    localparam op_t OP_ROT  = 3'd1;  // head leaves, bus enters at tail
    localparam op_t OP_DROP = 3'd2;  // head leaves, nothing enters
    localparam op_t OP_WR0  = 3'd3;  // bus overwrites head
    localparam op_t OP_ADD  = 3'd4;  // selected cell grows by bus length
    localparam op_t OP_INS  = 3'd5;  // bus inserted at pos, rest moves up

    typedef struct packed {
        op_t    op;
        entry_t bus;
        addr_t  key;
        cnt_t   cnt;
        cnt_t   pos;
    } chain_ctl_t;

endpackage

`default_nettype wire

[design/boot_range_allocator.sv]
// Boot range allocator top: command sequencer, reservation memory, output
// register. Depends on brng_pkg and brng_chain.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                                  | Role
// ---------+--------------------------------------------------------+--------
// command  | s_valid s_ready s_cmd s_range_start s_range_size       | in
//          | s_page_count                                           |
// result   | m_valid m_ready m_status m_alloc_address               | out
//
// The free table is a row of cells that rotates through cell 0; every walk
// looks at the head only and takes one walk step per entry. An allocate
// walks every entry; a reserve runs one carve walk, none for a zero-length
// reservation or a full table; an add puts the range in and then replays
// every reservation as a carve walk, none when the free table is full. A
// split puts the tail piece back, and a tail piece put back as a new entry
// is walked as one more entry.
// Reset clears counts and control only; no clearing pass. One command is in
// work at a time; the next transaction is taken as soon as the result sits
// in the output register, and a stalled result holds the sequencer only at
// its final step.

module boot_range_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [47:0] s_range_start,
    input  wire logic [47:0] s_range_size,
    input  wire logic [35:0] s_page_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [47:0]      m_alloc_address
);
    import brng_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_RSV_PREP  = 4'd1;
    localparam logic [3:0] S_RSV_ROUND = 4'd2;
    localparam logic [3:0] S_PF_SEARCH = 4'd3;
    localparam logic [3:0] S_PF_PICK   = 4'd4;
    localparam logic [3:0] S_RL_READ   = 4'd5;
    localparam logic [3:0] S_RL_LOAD   = 4'd6;
    localparam logic [3:0] S_CV_START  = 4'd7;
    localparam logic [3:0] S_CV_EXAM1  = 4'd8;
    localparam logic [3:0] S_CV_EXAM2  = 4'd9;
    localparam logic [3:0] S_CV_AFTER  = 4'd10;
    localparam logic [3:0] S_CV_END    = 4'd11;
    localparam logic [3:0] S_ALLOC     = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    // return points of the put-free and carve subroutines
    localparam logic PF_RET_ADD   = 1'b0;
    localparam logic PF_RET_CARVE = 1'b1;
    localparam logic CV_RET_RSV   = 1'b0;
    localparam logic CV_RET_LOOP  = 1'b1;

    localparam cnt_t DEPTH_C = cnt_t'(TABLE_DEPTH);

    // control state
    logic [3:0] state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;      // free entries
    cnt_t       rcnt_reg, rcnt_next;    // reservations
    cnt_t       k_reg, k_next;          // walk position
    cnt_t       r_reg, r_next;          // reservation replay index
    logic [1:0] status_reg, status_next;
    logic       pf_ret_reg, pf_ret_next;
    logic       cv_ret_reg, cv_ret_next;
    logic       found_reg, found_next;
    logic       m_valid_reg, m_valid_next;

    // datapath
    addr_t      s_reg, s_next, l_reg, l_next, len1_reg, len1_next;
    addr_t      need_reg, need_next, addr_reg, addr_next;
    addr_t      pf_s_reg, pf_s_next, pf_l_reg, pf_l_next;
    addr_t      cs_reg, cs_next, cl_reg, cl_next;
    addr_t      e_reg, e_next, sl_reg, sl_next;
    addr_t      re_reg, re_next, used_reg, used_next;
    addr_t      off_reg, off_next, rem_reg, rem_next;
    logic [1:0] m_status_reg, m_status_next;
    addr_t      m_addr_reg, m_addr_next;

    // reservation memory
    entry_t     resv_mem [TABLE_DEPTH];
    entry_t     rd_data_reg;
    logic       mem_we, mem_re;
    entry_t     mem_wdata;

    chain_ctl_t ctl;
    entry_t     head;
    logic       hit_any;
    logic       overlap;
    addr_t      rsv_base, rsv_len;

    brng_chain u_chain (
        .aclk    (aclk),
        .ctl     (ctl),
        .head    (head),
        .hit_any (hit_any)
    );

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_alloc_address = m_addr_reg;

    assign overlap  = (cs_reg <= re_reg) && (head.start <= e_reg);
    assign rsv_base = s_reg & ~PAGE_MASK;
    assign rsv_len  = (len1_reg + PAGE_MASK) & ~PAGE_MASK;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rcnt_next     = rcnt_reg;
        k_next        = k_reg;
        r_next        = r_reg;
        status_next   = status_reg;
        pf_ret_next   = pf_ret_reg;
        cv_ret_next   = cv_ret_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        s_next        = s_reg;
        l_next        = l_reg;
        len1_next     = len1_reg;
        need_next     = need_reg;
        addr_next     = addr_reg;
        pf_s_next     = pf_s_reg;
        pf_l_next     = pf_l_reg;
        cs_next       = cs_reg;
        cl_next       = cl_reg;
        e_next        = e_reg;
        sl_next       = sl_reg;
        re_next       = re_reg;
        used_next     = used_reg;
        off_next      = off_reg;
        rem_next      = rem_reg;
        m_status_next = m_status_reg;
        m_addr_next   = m_addr_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_wdata     = '{start: rsv_base, len: rsv_len};

        ctl.op  = OP_HOLD;
        ctl.bus = head;
        ctl.key = pf_s_reg;
        ctl.cnt = cnt_reg;
        ctl.pos = cnt_reg - k_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    k_next      = '0;
                    addr_next   = '0;
                    unique case (s_cmd)
                        CMD_ADD: begin
                            if (cnt_reg == DEPTH_C) begin
                                status_next = ST_FREE_FULL;
                                state_next  = S_DONE;
                            end else begin
                                pf_s_next   = s_range_start;
                                pf_l_next   = s_range_size;
                                pf_ret_next = PF_RET_ADD;
                                state_next  = S_PF_SEARCH;
                            end
                        end
                        CMD_RSV: begin
                            s_next     = s_range_start;
                            l_next     = s_range_size;
                            state_next = S_RSV_PREP;
                        end
                        CMD_ALLOC: begin
                            need_next = addr_t'(s_page_count) << PAGE_BITS;
                            if ((s_page_count >> (ADDR_W - PAGE_BITS)) != '0) begin
                                status_next = ST_ALLOC_FAIL;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_ALLOC;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RSV_PREP: begin
                len1_next  = l_reg + (s_reg & PAGE_MASK);
                state_next = S_RSV_ROUND;
            end

            S_RSV_ROUND: begin
                if (rcnt_reg == DEPTH_C) begin
                    status_next = ST_RESV_FULL;
                    state_next  = S_DONE;
                end else begin
                    mem_we      = 1'b1;
                    rcnt_next   = rcnt_reg + cnt_t'(1);
                    cs_next     = rsv_base;
                    cl_next     = rsv_len;
                    cv_ret_next = CV_RET_RSV;
                    state_next  = S_CV_START;
                end
            end

            // hit flags settle this cycle; full table means the piece is lost
            S_PF_SEARCH: begin
                if (cnt_reg == DEPTH_C) begin
                    status_next = ST_FREE_FULL;
                    if (pf_ret_reg == PF_RET_ADD) begin
                        r_next     = '0;
                        state_next = S_RL_READ;
                    end else begin
                        state_next = S_CV_AFTER;
                    end
                end else begin
                    state_next = S_PF_PICK;
                end
            end

            S_PF_PICK: begin
                if (hit_any) begin
                    ctl.op      = OP_ADD;
                    ctl.bus.len = pf_l_reg;
                end else begin
                    ctl.op   = OP_INS;
                    ctl.bus  = '{start: pf_s_reg, len: pf_l_reg};
                    cnt_next = cnt_reg + cnt_t'(1);
                end
                if (pf_ret_reg == PF_RET_ADD) begin
                    r_next     = '0;
                    state_next = S_RL_READ;
                end else begin
                    state_next = S_CV_AFTER;
                end
            end

            S_RL_READ: begin
                if (r_reg >= rcnt_reg) begin
                    state_next = S_DONE;
                end else begin
                    mem_re     = 1'b1;
                    state_next = S_RL_LOAD;
                end
            end

            S_RL_LOAD: begin
                cs_next     = rd_data_reg.start;
                cl_next     = rd_data_reg.len;
                cv_ret_next = CV_RET_LOOP;
                state_next  = S_CV_START;
            end

            S_CV_START: begin
                if (cl_reg == '0) begin
                    state_next = S_CV_END;
                end else begin
                    sl_next    = cs_reg + cl_reg;
                    e_next     = cs_reg + cl_reg - addr_t'(1);
                    k_next     = '0;
                    state_next = S_CV_EXAM1;
                end
            end

            S_CV_EXAM1: begin
                if (k_reg >= cnt_reg) begin
                    state_next = S_CV_END;
                end else begin
                    re_next    = head.start + head.len - addr_t'(1);
                    used_next  = cl_reg + cs_reg - head.start;
                    off_next   = cs_reg - head.start;
                    rem_next   = head.len + head.start - cs_reg;
                    state_next = S_CV_EXAM2;
                end
            end

            S_CV_EXAM2: begin
                state_next = S_CV_EXAM1;
                if (head.len == '0 || !overlap) begin
                    ctl.op = OP_ROT;
                    k_next = k_reg + cnt_t'(1);
                end else if (head.start >= cs_reg) begin
                    // front overlap: trim, or remove when fully covered
                    if (used_reg >= head.len) begin
                        ctl.op   = OP_DROP;
                        cnt_next = cnt_reg - cnt_t'(1);
                    end else begin
                        ctl.op  = OP_ROT;
                        ctl.bus = '{start: sl_reg, len: head.len - used_reg};
                        k_next  = k_reg + cnt_t'(1);
                    end
                end else if (cl_reg < rem_reg) begin
                    // split: keep front piece, put the tail back as free
                    ctl.op      = OP_WR0;
                    ctl.bus     = '{start: head.start, len: off_reg};
                    pf_s_next   = sl_reg;
                    pf_l_next   = rem_reg - cl_reg;
                    pf_ret_next = PF_RET_CARVE;
                    state_next  = S_PF_SEARCH;
                end else begin
                    // tail overlap: truncate at reservation start
                    ctl.op  = OP_ROT;
                    ctl.bus = '{start: head.start, len: off_reg};
                    k_next  = k_reg + cnt_t'(1);
                end
            end

            S_CV_AFTER: begin
                ctl.op     = OP_ROT;
                k_next     = k_reg + cnt_t'(1);
                state_next = S_CV_EXAM1;
            end

            S_CV_END: begin
                if (cv_ret_reg == CV_RET_RSV) begin
                    state_next = S_DONE;
                end else begin
                    r_next     = r_reg + cnt_t'(1);
                    state_next = S_RL_READ;
                end
            end

            // first fit; the walk goes on to bring the table back in order
            S_ALLOC: begin
                if (k_reg >= cnt_reg) begin
                    status_next = found_reg ? ST_OK : ST_ALLOC_FAIL;
                    state_next  = S_DONE;
                end else if (!found_reg && head.len >= need_reg) begin
                    addr_next  = head.start;
                    found_next = 1'b1;
                    if (head.len == need_reg) begin
                        ctl.op   = OP_DROP;
                        cnt_next = cnt_reg - cnt_t'(1);
                    end else begin
                        ctl.op  = OP_ROT;
                        ctl.bus = '{start: head.start + need_reg,
                                    len: head.len - need_reg};
                        k_next  = k_reg + cnt_t'(1);
                    end
                end else begin
                    ctl.op = OP_ROT;
                    k_next = k_reg + cnt_t'(1);
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_addr_next   = addr_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            rcnt_reg    <= '0;
            k_reg       <= '0;
            r_reg       <= '0;
            status_reg  <= ST_OK;
            pf_ret_reg  <= PF_RET_ADD;
            cv_ret_reg  <= CV_RET_RSV;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rcnt_reg    <= rcnt_next;
            k_reg       <= k_next;
            r_reg       <= r_next;
            status_reg  <= status_next;
            pf_ret_reg  <= pf_ret_next;
            cv_ret_reg  <= cv_ret_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg        <= s_next;
        l_reg        <= l_next;
        len1_reg     <= len1_next;
        need_reg     <= need_next;
        addr_reg     <= addr_next;
        pf_s_reg     <= pf_s_next;
        pf_l_reg     <= pf_l_next;
        cs_reg       <= cs_next;
        cl_reg       <= cl_next;
        e_reg        <= e_next;
        sl_reg       <= sl_next;
        re_reg       <= re_next;
        used_reg     <= used_next;
        off_reg      <= off_next;
        rem_reg      <= rem_next;
        m_status_reg <= m_status_next;
        m_addr_reg   <= m_addr_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            resv_mem[rcnt_reg[IDX_W-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= resv_mem[r_reg[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

[design/brng_cell.sv]
// One free-table cell: holds a single range and moves it to or from its
// neighbors on the chain command. Depends on brng_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brng_cell (
    input  wire logic                aclk,
    input  wire brng_pkg::idx_t      cell_idx,
    input  wire brng_pkg::chain_ctl_t ctl,
    input  wire logic                sel,
    input  wire brng_pkg::entry_t    from_left,
    input  wire brng_pkg::entry_t    from_right,
    output brng_pkg::entry_t         entry_q,
    output logic                     hit_q
);
    import brng_pkg::*;

    entry_t entry_reg, entry_next;
    logic   hit_reg;
    cnt_t   idx_c;
    cnt_t   idx_p1;

    assign idx_c  = cnt_t'(cell_idx);
    assign idx_p1 = idx_c + cnt_t'(1);

    always_comb begin
        entry_next = entry_reg;
        unique case (ctl.op)
            OP_ROT: begin
                if (idx_p1 == ctl.cnt) begin
                    entry_next = ctl.bus;
                end else if (idx_p1 < ctl.cnt) begin
                    entry_next = from_right;
                end
            end
            OP_DROP: begin
                if (idx_p1 < ctl.cnt) begin
                    entry_next = from_right;
                end
            end
            OP_WR0: begin
                if (cell_idx == '0) begin
                    entry_next = ctl.bus;
                end
            end
            OP_ADD: begin
                if (sel) begin
                    entry_next.len = entry_reg.len + ctl.bus.len;
                end
            end
            OP_INS: begin
                if (idx_c == ctl.pos) begin
                    entry_next = ctl.bus;
                end else if (idx_c > ctl.pos && idx_c <= ctl.cnt) begin
                    entry_next = from_left;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        // merge candidate: this range ends where the key starts
        hit_reg   <= ((entry_reg.start + entry_reg.len) == ctl.key);
    end

    assign entry_q = entry_reg;
    assign hit_q   = hit_reg;

endmodule

`default_nettype wire

[design/brng_chain.sv]
// Row of free-table cells plus the merge-target pick over their hit flags.
// Depends on brng_pkg and brng_cell.
`timescale 1ns / 1ps
`default_nettype none

module brng_chain (
    input  wire logic                 aclk,
    input  wire brng_pkg::chain_ctl_t ctl,
    output brng_pkg::entry_t          head,
    output logic                      hit_any
);
    import brng_pkg::*;

    localparam int LOG_D = $clog2(TABLE_DEPTH);

    typedef logic [TABLE_DEPTH-1:0] row_t;

    entry_t ents [TABLE_DEPTH];
    row_t   hits;
    row_t   mask_a, mask_b, hit_a, hit_b, oh_a, oh_b, sel;

    // keep only the highest set bit
    function automatic row_t top_one(input row_t v);
        row_t g;
        g = v;
        for (int j = 0; j < LOG_D; j++) begin
            g = g | (g >> (1 << j));
        end
        return v & ~(g >> 1);
    endfunction

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        entry_t left_in, right_in;
        if (i == 0) begin : g_first
            assign left_in = ctl.bus;
        end else begin : g_mid_l
            assign left_in = ents[i-1];
        end
        if (i == TABLE_DEPTH - 1) begin : g_last
            assign right_in = ctl.bus;
        end else begin : g_mid_r
            assign right_in = ents[i+1];
        end

        // unprocessed entries sit below pos, already walked ones above
        assign mask_a[i] = (cnt_t'(i) < ctl.pos);
        assign mask_b[i] = (cnt_t'(i) >= ctl.pos) && (cnt_t'(i) < ctl.cnt);

        brng_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (idx_t'(i)),
            .ctl        (ctl),
            .sel        (sel[i]),
            .from_left  (left_in),
            .from_right (right_in),
            .entry_q    (ents[i]),
            .hit_q      (hits[i])
        );
    end

    always_comb begin
        hit_a   = hits & mask_a;
        hit_b   = hits & mask_b;
        oh_a    = top_one(hit_a);
        oh_b    = top_one(hit_b);
        sel     = (|hit_a) ? oh_a : oh_b;
        hit_any = |(hit_a | hit_b);
    end

    assign head = ents[0];

endmodule

`default_nettype wire

[dv/tb_boot_range_allocator.sv]
// Self-checking testbench for boot_range_allocator: a queue-fed driver, a monitor
// and an in-bench prediction of the free and reservation tables. Depends on brng_pkg.
`timescale 1ns / 1ps

module tb_boot_range_allocator;
    import brng_pkg::*;

    // command code with no defined meaning
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct {
        logic [1:0]         cmd;
        addr_t              start;
        addr_t              size;
        logic [PAGES_W-1:0] pages;
    } command_t;

    typedef struct {
        logic [1:0] status;
        addr_t      address;
    } outcome_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd = CMD_ADD;
    logic [47:0]        s_range_start = '0;
    logic [47:0]        s_range_size = '0;
    logic [35:0]        s_page_count = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [47:0]        m_alloc_address;

    command_t pending_cmds[$];
    outcome_t expected_outcomes[$];
    int       error_count = 0;
    int       accepted_count = 0;
    bit       rx_hold = 1'b0;        // long receiver hold-off
    bit       stim_done = 1'b0;

    // Mirrored allocator state
    addr_t free_base[TABLE_DEPTH];
    addr_t free_len[TABLE_DEPTH];
    int    free_cnt = 0;
    addr_t resv_base[TABLE_DEPTH];
    addr_t resv_len[TABLE_DEPTH];
    int    resv_cnt = 0;

    boot_range_allocator u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_range_start   (s_range_start),
        .s_range_size    (s_range_size),
        .s_page_count    (s_page_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_alloc_address (m_alloc_address)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Free-table model
    // ------------------------------------------------------------------
    function automatic void remove_free(int k);
        for (int j = k; j < free_cnt - 1; j++) begin
            free_base[j] = free_base[j+1];
            free_len[j]  = free_len[j+1];
        end
        free_cnt--;
    endfunction

    // Merge into an entry ending at s (searched from the top), else append.
    function automatic bit insert_free(addr_t s, addr_t l);
        if (free_cnt >= TABLE_DEPTH) return 1'b0;
        for (int k = free_cnt; k > 0; k--) begin
            if (free_base[k-1] + free_len[k-1] == s) begin
                free_len[k-1] = free_len[k-1] + l;
                return 1'b1;
            end
        end
        free_base[free_cnt] = s;
        free_len[free_cnt]  = l;
        free_cnt++;
        return 1'b1;
    endfunction

    // Cut [s, s+l) out of every overlapping free range; 0 if a split was lost.
    function automatic bit cut_reservation(addr_t s, addr_t l);
        int    k;
        bit    ok;
        addr_t e, rs, rl, re, used, off, rem, shave;
        ok = 1'b1;
        k  = 0;
        if (l == 0) return 1'b1;
        e = s + l - 1;
        while (k < free_cnt) begin
            rs = free_base[k];
            rl = free_len[k];
            if (rl == 0) begin
                k++;
                continue;
            end
            re = rs + rl - 1;
            if (!(s <= re && rs <= e)) begin
                k++;
                continue;
            end
            if (rs >= s) begin
                used = l - (rs - s);
                if (used >= rl) begin
                    remove_free(k);   // successor slides into slot k, look again
                    continue;
                end
                free_len[k]  = rl - used;
                free_base[k] = rs + used;
            end else begin
                off   = s - rs;
                rem   = rl - off;
                shave = (l < rem) ? l : rem;
                free_len[k] = off;   // tail overlap truncates here
                if (shave != rem && !insert_free(s + shave, rem - shave))
                    ok = 1'b0;
            end
            k++;
        end
        return ok;
    endfunction

    function automatic outcome_t allocator_outcome(command_t c);
        outcome_t o;
        addr_t    base, len, need;
        o.status  = ST_OK;
        o.address = '0;
        case (c.cmd)
            CMD_ADD: begin
                if (!insert_free(c.start, c.size)) begin
                    o.status = ST_FREE_FULL;
                end else begin
                    for (int k = 0; k < resv_cnt; k++)
                        if (!cut_reservation(resv_base[k], resv_len[k]))
                            o.status = ST_FREE_FULL;
                end
            end
            CMD_RSV: begin
                len  = c.size + (c.start & PAGE_MASK);
                base = c.start & ~PAGE_MASK;
                len  = (len + PAGE_MASK) & ~PAGE_MASK;
                if (resv_cnt >= TABLE_DEPTH) begin
                    o.status = ST_RESV_FULL;
                end else begin
                    resv_base[resv_cnt] = base;
                    resv_len[resv_cnt]  = len;
                    resv_cnt++;
                    if (!cut_reservation(base, len)) o.status = ST_FREE_FULL;
                end
            end
            CMD_ALLOC: begin
                o.status = ST_ALLOC_FAIL;
                need = addr_t'({12'd0, c.pages} << PAGE_BITS);
                for (int k = 0; k < free_cnt; k++) begin
                    if (free_len[k] >= need) begin
                        o.address    = free_base[k];
                        free_base[k] = free_base[k] + need;
                        free_len[k]  = free_len[k] - need;
                        if (free_len[k] == 0) remove_free(k);
                        o.status = ST_OK;
                        break;
                    end
                end
            end
            default: ;   // unknown command: no effect
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("%0t mismatch on %s: got 'h%0h, want 'h%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: one transaction at a time from pending_cmds, random gaps
    // ------------------------------------------------------------------
    int tx_gap = 0;
    bit tx_quiet = 1'b0;

    always @(posedge aclk) begin
        command_t c;
        bit       busy;
        busy = s_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                c.cmd = s_cmd;  c.start = s_range_start;
                c.size = s_range_size;  c.pages = s_page_count;
                expected_outcomes.push_back(allocator_outcome(c));
                accepted_count++;
                busy = 1'b0;
                if ($urandom_range(0, 29) == 0) tx_quiet = ~tx_quiet;
                tx_gap = tx_quiet ? 0 : $urandom_range(0, 6);
            end
            if (!busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    s_valid       <= 1'b1;
                    s_cmd         <= c.cmd;
                    s_range_start <= c.start;
                    s_range_size  <= c.size;
                    s_page_count  <= c.pages;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction, random back-pressure
    // ------------------------------------------------------------------
    int rx_stall = 0;
    bit rx_quiet = 1'b0;

    always @(posedge aclk) begin
        outcome_t o;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected result", 48'(m_status), '0);
                end else begin
                    o = expected_outcomes.pop_front();
                    if (m_status !== o.status)
                        report_mismatch("status", 48'(m_status), 48'(o.status));
                    if (m_alloc_address !== o.address)
                        report_mismatch("alloc_address", m_alloc_address, o.address);
                end
                if ($urandom_range(0, 29) == 0) rx_quiet = ~rx_quiet;
                rx_stall = rx_quiet ? 0 : $urandom_range(0, 6);
            end
            if (rx_hold) begin
                m_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Long hold-off: the block holds one result and then blocks its input.
    initial begin
        wait (accepted_count >= 60);
        @(posedge aclk) rx_hold <= 1'b1;
        repeat (3000) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic command_t mk(logic [1:0] cmd, addr_t s, addr_t l,
                                    logic [PAGES_W-1:0] p);
        command_t c;
        c.cmd = cmd;  c.start = s;  c.size = l;  c.pages = p;
        return c;
    endfunction

    function automatic addr_t rnd_addr();
        return {16'($urandom_range(0, 65535)), $urandom()};
    endfunction

    // Mostly page-scale addresses in a small window so ranges collide.
    function automatic addr_t near_addr();
        if ($urandom_range(0, 9) == 0) return rnd_addr();
        return addr_t'($urandom_range(0, 96)) * 4096 + ($urandom_range(0, 3) == 0 ?
               addr_t'($urandom_range(0, 4095)) : '0);
    endfunction

    function automatic addr_t near_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return rnd_addr();
            2:       return addr_t'($urandom_range(1, 5000));
            default: return addr_t'($urandom_range(1, 12)) * 4096;
        endcase
    endfunction

    function automatic logic [PAGES_W-1:0] rnd_pages();
        case ($urandom_range(0, 9))
            0:       return {4'($urandom_range(0, 15)), $urandom()};
            1:       return '0;
            default: return PAGES_W'($urandom_range(1, 8));
        endcase
    endfunction

    initial begin
        addr_t all1;
        int    pick;
        all1 = '1;

        // Directed part
        pending_cmds.push_back(mk(CMD_ALLOC, '0, '0, '0));               // empty table
        pending_cmds.push_back(mk(CMD_ADD, 48'h10_0000, 48'h8000, '0));
        pending_cmds.push_back(mk(CMD_ADD, 48'h10_8000, 48'h4000, '0));  // merges
        pending_cmds.push_back(mk(CMD_ADD, 48'h40_0000, '0, '0));        // zero length
        pending_cmds.push_back(mk(CMD_RSV, 48'h10_2345, 48'h1000, '0));  // unaligned split
        pending_cmds.push_back(mk(CMD_RSV, 48'h10_0000, 48'h1000, '0));  // head trim
        pending_cmds.push_back(mk(CMD_RSV, 48'h10_B000, 48'h10000, '0)); // tail overlap
        pending_cmds.push_back(mk(CMD_RSV, 48'h10_4000, 48'h7000, '0));  // whole entry
        pending_cmds.push_back(mk(CMD_RSV, 48'h70_0000, '0, '0));        // zero reservation
        pending_cmds.push_back(mk(CMD_ALLOC, '0, '0, '0));               // zero pages
        pending_cmds.push_back(mk(CMD_ALLOC, '0, '0, 36'd1));
        pending_cmds.push_back(mk(CMD_ALLOC, all1, all1, '1));           // too big
        pending_cmds.push_back(mk(CMD_UNKNOWN, all1, all1, '1));         // unknown command
        pending_cmds.push_back(mk(CMD_ADD, 48'h20_0000, 48'h3000, '0));  // re-carved on add
        pending_cmds.push_back(mk(CMD_ADD, all1, all1, '0));             // wraps
        pending_cmds.push_back(mk(CMD_ALLOC, '0, '0, 36'd2));
        pending_cmds.push_back(mk(CMD_RSV, all1, all1, '0));
        pending_cmds.push_back(mk(CMD_ADD, 48'h80_0000, 48'h40_0000, '0));
        pending_cmds.push_back(mk(CMD_ALLOC, '0, '0, 36'd3));
        pending_cmds.push_back(mk(CMD_ALLOC, '0, '0, '0));

        // Scattered one-page ranges that cannot merge: drives the free table full
        for (int i = 0; i < 140; i++)
            pending_cmds.push_back(mk(CMD_ADD, 48'h1000_0000 + addr_t'(i) * 48'h2000,
                                      48'h1000, '0));

        // Mixed traffic, mostly within the crowded window
        for (int i = 0; i < 300; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                pending_cmds.push_back(mk(CMD_ALLOC, rnd_addr(), rnd_addr(), rnd_pages()));
            else if (pick < 85)
                pending_cmds.push_back(mk(CMD_ADD, near_addr(), near_size(), rnd_pages()));
            else if (pick < 93)
                pending_cmds.push_back(mk(CMD_RSV, near_addr(), near_size(), rnd_pages()));
            else
                pending_cmds.push_back(mk(CMD_UNKNOWN, rnd_addr(), rnd_addr(), rnd_pages()));
        end

        // Fill the reservation table past its depth; reserves stay cheap
        for (int i = 0; i < 120; i++)
            pending_cmds.push_back(mk(CMD_RSV, near_addr(), addr_t'($urandom_range(0, 9000)),
                                      '0));
        for (int i = 0; i < 8; i++)
            pending_cmds.push_back(mk(CMD_ALLOC, '0, '0, rnd_pages()));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_cmds.size() == 0 && !s_valid && expected_outcomes.size() == 0);
        repeat (50) @(posedge aclk);
        if (error_count == 0 && expected_outcomes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
